@@ hw/rtl/sem_pkg.sv @@
package sem_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int SRV_W       = $clog2(MAX_SERVERS);
  localparam int SF_W        = $clog2(MAX_SERVERS + 1);
  localparam int STRIP_W     = 32;
  localparam int STRIPE_W    = 36;
  localparam int DATA_W      = 64;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STAGES  = DATA_W / DIV_BITS;
  localparam int POST_STAGES = 7;
  localparam int NSTG        = DIV_STAGES + POST_STAGES;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_BYTES  = 2'd1;

  localparam logic [SF_W-1:0]    SF_RESET    = 5'd1;
  localparam logic [STRIP_W-1:0] STRIP_RESET = 32'd65536;

  typedef struct packed {
    logic [63:0] logical_offset;
    logic [63:0] logical_length;
  } in_t;

  typedef struct packed {
    logic [3:0]  server_index;
    logic [63:0] object_offset;
    logic [63:0] object_length;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic [DATA_W-1:0]   qr;
    logic [STRIPE_W-1:0] rm;
  } div_st_t;

  // bytes on one server whose next strip starts ks bytes into the stripe grid
  function automatic logic [DATA_W-1:0] tail_bytes(
    logic [STRIPE_W-1:0] r,
    logic [STRIPE_W-1:0] ks,
    logic [STRIPE_W-1:0] stripe,
    logic [STRIP_W-1:0]  strip,
    logic [DATA_W-1:0]   p,
    logic [DATA_W-1:0]   pm
  );
    logic [STRIPE_W:0] rr;
    logic [STRIPE_W:0] m;
    logic [DATA_W-1:0] b;
    if (r >= ks) begin
      rr = {1'b0, r} - {1'b0, ks};
      b  = p;
    end else begin
      rr = {1'b0, r} + {1'b0, stripe} - {1'b0, ks};
      b  = pm;
    end
    m = (rr < (STRIPE_W+1)'(strip)) ? rr : (STRIPE_W+1)'(strip);
    return b + DATA_W'(m);
  endfunction

endpackage

@@ hw/rtl/stripe_extent_mapper.sv @@
// an item passes the divider stages, the arithmetic stages and the result sequencer before
// its first result is registered at the port; then come its results one a cycle, one per server
// the front end (two 16-stage dividers, 7 arithmetic stages) takes an item every cycle
// and stalls as a whole only while the result sequencer still holds an earlier item
// reset (synchronous, rst_n low) empties the pipeline and loads 1 server, 65536-byte strips
module stripe_extent_mapper (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  sem_pkg::in_t                    in_data,
  output logic                            out_valid,
  output sem_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [sem_pkg::STRIP_W-1:0]     cfg_data
);

  localparam int DW = sem_pkg::DATA_W;
  localparam int SW = sem_pkg::STRIPE_W;
  localparam int TW = sem_pkg::STRIP_W;
  localparam int NW = sem_pkg::SRV_W;
  localparam int FW = sem_pkg::SF_W;
  localparam int NS = sem_pkg::NSTG;
  localparam int MS = sem_pkg::MAX_SERVERS;
  localparam int DS = sem_pkg::DIV_STAGES;

  // configuration
  logic [FW-1:0] sf_r, sf_nxt;
  logic [TW-1:0] strip_r, strip_nxt;
  logic [SW-1:0] stripe_r, stripe_nxt;
  logic [SW-1:0] jstrip_r [MS];
  logic [SW-1:0] jstrip_nxt [MS];

  always_comb begin
    sf_nxt    = sf_r;
    strip_nxt = strip_r;
    if (cfg_we) begin
      case (cfg_idx)
        sem_pkg::CFG_SERVER_COUNT: begin
          if (cfg_data[FW-1:0] == '0) sf_nxt = FW'(1);
          else if (cfg_data[FW-1:0] > FW'(MS)) sf_nxt = FW'(MS);
          else sf_nxt = cfg_data[FW-1:0];
        end
        sem_pkg::CFG_STRIP_BYTES: begin
          strip_nxt = (cfg_data == '0) ? TW'(1) : cfg_data;
        end
        default: ;
      endcase
    end
    stripe_nxt = SW'(sf_nxt) * SW'(strip_nxt);
    for (int j = 0; j < MS; j++) begin
      jstrip_nxt[j] = SW'(j) * SW'(strip_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r     <= sem_pkg::SF_RESET;
      strip_r  <= sem_pkg::STRIP_RESET;
      stripe_r <= SW'(sem_pkg::SF_RESET) * SW'(sem_pkg::STRIP_RESET);
      for (int j = 0; j < MS; j++) begin
        jstrip_r[j] <= SW'(j) * SW'(sem_pkg::STRIP_RESET);
      end
    end else begin
      sf_r     <= sf_nxt;
      strip_r  <= strip_nxt;
      stripe_r <= stripe_nxt;
      for (int j = 0; j < MS; j++) begin
        jstrip_r[j] <= jstrip_nxt[j];
      end
    end
  end

  // pipeline control
  logic [NS-1:0] vld_r;
  logic          adv;
  logic          seq_active_r;
  logic          seq_last;
  logic          seq_load;
  logic [NW-1:0] k_r;

  assign seq_last = seq_active_r && ({1'b0, k_r} == sf_r - FW'(1));
  assign seq_load = vld_r[NS-1] && (!seq_active_r || seq_last);
  assign adv      = !vld_r[NS-1] || seq_load;
  assign busy     = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], start};
    end
  end

  // dividers: offset and length by the stripe
  logic [DW-1:0] qo, ql;
  logic [SW-1:0] wo, rl;
  logic [DW-1:0] len_r [DS];

  sem_div u_div_off (
    .clk   (clk),
    .en    (adv),
    .dvd_i (in_data.logical_offset),
    .dsr_i (stripe_r),
    .quo_o (qo),
    .rem_o (wo)
  );

  sem_div u_div_len (
    .clk   (clk),
    .en    (adv),
    .dvd_i (in_data.logical_length),
    .dsr_i (stripe_r),
    .quo_o (ql),
    .rem_o (rl)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      len_r[0] <= in_data.logical_length;
      for (int s = 1; s < DS; s++) begin
        len_r[s] <= len_r[s-1];
      end
    end
  end

  // first server: how many nonzero strip multiples lie at or below the offset in its stripe
  logic [NW-1:0] fs_cnt;
  always_comb begin
    fs_cnt = '0;
    for (int j = 1; j < MS; j++) begin
      if (FW'(j) < sf_r && jstrip_r[j] <= wo) fs_cnt = fs_cnt + NW'(1);
    end
  end

  // stage registers
  logic [NW-1:0]   s1_fs, s2_fs, s3_fs, s4_fs, s5_fs, s6_fs, s7_fs;
  logic [SW-1:0]   s1_w;
  logic [DW-1:0]   s1_mlo, s4_qlo;
  logic [TW-1:0]   s1_mhi, s4_qhi;
  logic [DW-1:0]   s1_len, s2_len, s3_len, s4_len, s5_len, s6_mlr;
  logic [DW-1:0]   s1_ql, s2_ql;
  logic [SW-1:0]   s1_rl, s2_rl;
  logic [TW-1:0]   s2_adj, s3_adj, s4_adj, s5_adj;
  logic [DW-1:0]   s2_base, s3_base, s4_base, s5_base, s6_base, s7_base;
  logic [SW-1:0]   s3_r, s4_r, s5_r, s6_r, s7_r;
  logic [DW:0]     s3_q;
  logic [DW:0]     s3_l, s4_l, s5_l, s6_l, s7_l;
  logic [DW-1:0]   s5_p, s5_pm, s6_p, s6_pm, s7_p, s7_pm;
  logic [DW-1:0]   s6_tail0, s6_off0, s7_off0, s7_len0;
  logic            s6_nz, s7_nz;
  logic [SW:0]     r1;

  assign r1 = {1'b0, s2_rl} + (SW+1)'(s2_adj);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_fs   <= fs_cnt;
      s1_w    <= wo;
      s1_mlo  <= {32'b0, qo[31:0]} * {32'b0, strip_r};
      s1_mhi  <= TW'(qo[63:32] * strip_r);
      s1_len  <= len_r[DS-1];
      s1_ql   <= ql;
      s1_rl   <= rl;

      s2_fs   <= s1_fs;
      s2_adj  <= TW'(s1_w - jstrip_r[s1_fs]);
      s2_base <= s1_mlo + {s1_mhi, 32'b0};
      s2_len  <= s1_len;
      s2_ql   <= s1_ql;
      s2_rl   <= s1_rl;

      s3_fs   <= s2_fs;
      s3_adj  <= s2_adj;
      s3_base <= s2_base;
      s3_len  <= s2_len;
      s3_l    <= {1'b0, s2_len} + (DW+1)'(s2_adj);
      if (r1 >= {1'b0, stripe_r}) begin
        s3_r <= SW'(r1 - {1'b0, stripe_r});
        s3_q <= {1'b0, s2_ql} + (DW+1)'(1);
      end else begin
        s3_r <= SW'(r1);
        s3_q <= {1'b0, s2_ql};
      end

      s4_fs   <= s3_fs;
      s4_adj  <= s3_adj;
      s4_base <= s3_base;
      s4_len  <= s3_len;
      s4_l    <= s3_l;
      s4_r    <= s3_r;
      s4_qlo  <= {32'b0, s3_q[31:0]} * {32'b0, strip_r};
      s4_qhi  <= TW'(s3_q[63:32] * strip_r);

      s5_fs   <= s4_fs;
      s5_adj  <= s4_adj;
      s5_base <= s4_base;
      s5_len  <= s4_len;
      s5_l    <= s4_l;
      s5_r    <= s4_r;
      s5_p    <= s4_qlo + {s4_qhi, 32'b0};
      s5_pm   <= s4_qlo + {s4_qhi, 32'b0} - DW'(strip_r);

      // first server: head of its strip plus full later strips
      s6_fs    <= s5_fs;
      s6_base  <= s5_base;
      s6_l     <= s5_l;
      s6_r     <= s5_r;
      s6_p     <= s5_p;
      s6_pm    <= s5_pm;
      s6_nz    <= (s5_len != '0);
      s6_off0  <= s5_base + DW'(s5_adj);
      s6_tail0 <= (s5_l > (DW+1)'(stripe_r)) ?
                  sem_pkg::tail_bytes(s5_r, stripe_r, stripe_r, strip_r, s5_p, s5_pm) : '0;
      s6_mlr   <= (s5_len < DW'(strip_r - s5_adj)) ? s5_len : DW'(strip_r - s5_adj);

      s7_fs   <= s6_fs;
      s7_base <= s6_base;
      s7_l    <= s6_l;
      s7_r    <= s6_r;
      s7_p    <= s6_p;
      s7_pm   <= s6_pm;
      s7_nz   <= s6_nz;
      s7_off0 <= s6_off0;
      s7_len0 <= s6_mlr + s6_tail0;
    end
  end

  // result sequencer: one result per server
  logic [NW-1:0] idx_r, idx_nxt, k_nxt;
  logic [SW-1:0] ks_r, ks_nxt;
  logic          seq_active_nxt;
  logic [NW-1:0] sq_fs;
  logic [DW-1:0] sq_base, sq_off0, sq_len0, sq_p, sq_pm;
  logic [SW-1:0] sq_r;
  logic [DW:0]   sq_l;
  logic          sq_nz;
  logic          out_valid_r, out_valid_nxt;
  sem_pkg::out_t out_data_r, out_data_nxt;

  always_comb begin
    seq_active_nxt = seq_active_r;
    k_nxt          = k_r;
    idx_nxt        = idx_r;
    ks_nxt         = ks_r;
    if (seq_load) begin
      seq_active_nxt = 1'b1;
      k_nxt          = '0;
      idx_nxt        = s7_fs;
      ks_nxt         = SW'(strip_r);
    end else if (seq_last) begin
      seq_active_nxt = 1'b0;
    end else if (seq_active_r) begin
      k_nxt   = k_r + NW'(1);
      idx_nxt = ({1'b0, idx_r} + FW'(1) == sf_r) ? '0 : idx_r + NW'(1);
      if (k_r != '0) ks_nxt = ks_r + SW'(strip_r);
    end

    out_valid_nxt             = seq_active_r;
    out_data_nxt.server_index = 4'(idx_r);
    out_data_nxt.last_result  = seq_last;
    out_data_nxt.object_offset = '0;
    out_data_nxt.object_length = '0;
    if (k_r == '0) begin
      if (sq_nz) begin
        out_data_nxt.object_offset = sq_off0;
        out_data_nxt.object_length = sq_len0;
      end
    end else if (sq_l > (DW+1)'(ks_r)) begin
      out_data_nxt.object_offset = sq_base + ((idx_r < sq_fs) ? DW'(strip_r) : '0);
      out_data_nxt.object_length =
        sem_pkg::tail_bytes(sq_r, ks_r, stripe_r, strip_r, sq_p, sq_pm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_active_r <= 1'b0;
      out_valid_r  <= 1'b0;
      k_r          <= '0;
    end else begin
      seq_active_r <= seq_active_nxt;
      out_valid_r  <= out_valid_nxt;
      k_r          <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    ks_r       <= ks_nxt;
    out_data_r <= out_data_nxt;
    if (seq_load) begin
      sq_fs   <= s7_fs;
      sq_base <= s7_base;
      sq_off0 <= s7_off0;
      sq_len0 <= s7_len0;
      sq_p    <= s7_p;
      sq_pm   <= s7_pm;
      sq_r    <= s7_r;
      sq_l    <= s7_l;
      sq_nz   <= s7_nz;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_busy_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> vld_r[NS-1] && seq_active_r && !seq_last)
    else $error("busy without a blocked item");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    seq_active_r |-> ({1'b0, k_r} < sf_r))
    else $error("result counter beyond server count");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (FW'(out_data_r.server_index) < sf_r))
    else $error("server index beyond server count");

  a_results_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.last_result |=> out_valid_r)
    else $error("gap inside the results of one item");

endmodule

@@ hw/rtl/sem_div.sv @@
module sem_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [sem_pkg::DATA_W-1:0]    dvd_i,
  input  logic [sem_pkg::STRIPE_W-1:0]  dsr_i,
  output logic [sem_pkg::DATA_W-1:0]    quo_o,
  output logic [sem_pkg::STRIPE_W-1:0]  rem_o
);

  sem_pkg::div_st_t st_r [sem_pkg::DIV_STAGES];

  function automatic sem_pkg::div_st_t div_step(sem_pkg::div_st_t a,
                                                logic [sem_pkg::STRIPE_W-1:0] d);
    sem_pkg::div_st_t           o;
    logic [sem_pkg::STRIPE_W:0] t;
    o = a;
    for (int i = 0; i < sem_pkg::DIV_BITS; i++) begin
      t    = {o.rm, o.qr[sem_pkg::DATA_W-1]};
      o.qr = {o.qr[sem_pkg::DATA_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t       = t - {1'b0, d};
        o.qr[0] = 1'b1;
      end
      o.rm = t[sem_pkg::STRIPE_W-1:0];
    end
    return o;
  endfunction

  // dividend shifts out the top while quotient bits shift in at the bottom
  for (genvar s = 0; s < sem_pkg::DIV_STAGES; s++) begin : g_stg
    sem_pkg::div_st_t st_in;
    if (s == 0) begin : g_first
      assign st_in = '{qr: dvd_i, rm: '0};
    end else begin : g_next
      assign st_in = st_r[s-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[s] <= div_step(st_in, dsr_i);
      end
    end
  end

  assign quo_o = st_r[sem_pkg::DIV_STAGES-1].qr;
  assign rem_o = st_r[sem_pkg::DIV_STAGES-1].rm;

endmodule
